FILE: src/acl_pkg.sv
// acl_pkg: token kinds, lexer modes, token and result-pair structs, character constants.
// Used by the lexer core, the result queue and the top level. No dependencies.
`timescale 1ns / 1ps

package acl_pkg;

    typedef enum logic [3:0] {
        K_LOCAL    = 4'd0,
        K_IDENT    = 4'd1,
        K_ASSIGN   = 4'd2,
        K_COMMA    = 4'd3,
        K_STRING   = 4'd4,
        K_NUMBER   = 4'd5,
        K_LPAREN   = 4'd6,
        K_RPAREN   = 4'd7,
        K_END      = 4'd8,
        K_UNCLOSED = 4'd9,
        K_UNKNOWN  = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_NUM   = 3'd1,
        M_IDENT = 3'd2,
        M_STR   = 3'd3,
        M_ERR   = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    // Results of one accepted item: tok0 first, tok1 only when two is set
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_pair;

    localparam int          OUT_TDATA_BITS = 40;
    localparam logic [7:0]  CH_UNDERSCORE  = 8'h5F;
    localparam logic [7:0]  CH_ASSIGN      = 8'h3D;
    localparam logic [7:0]  CH_COMMA       = 8'h2C;
    localparam logic [7:0]  CH_LPAREN      = 8'h28;
    localparam logic [7:0]  CH_RPAREN      = 8'h29;
    localparam logic [7:0]  CH_QUOTE       = 8'h22;
    localparam logic [7:0]  CH_NUL         = 8'h00;
    localparam logic [2:0]  KW_LEN         = 3'd5;

    // Characters of the keyword "local"
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6C; // l
            3'd1:    ch = 8'h6F; // o
            3'd2:    ch = 8'h63; // c
            3'd3:    ch = 8'h61; // a
            3'd4:    ch = 8'h6C; // l
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

FILE: src/acl_lex_core.sv
// acl_lex_core: lexer state registers and the single-pass step that turns one byte into
// up to two tokens. Depends on acl_pkg.
`timescale 1ns / 1ps

module acl_lex_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_end,
    output logic          o_push,
    output acl_pkg::t_pair o_pair
);
    import acl_pkg::*;

    localparam int PW = POSITION_BITS;

    t_mode          r_mode, n_mode;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_origin, n_origin;
    logic [PW-1:0]  r_run, n_run;
    logic           r_kw, n_kw;

    logic   va, vb, do_idle, is_end, ident_ch, kw_hit;
    t_token ta, tb;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == {PW{1'b1}}) ? v : v + PW'(1);
    endfunction

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        logic [PW+15:0] w;
        w = {16'b0, v};
        if ((w >> 16) != '0) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic t_token mk(input t_kind k, input logic [PW-1:0] s,
                                  input logic [PW-1:0] l);
        t_token t;
        t.kind   = k;
        t.start  = sat16(s);
        t.length = sat16(l);
        return t;
    endfunction

    assign is_end   = i_end || (i_byte == CH_NUL);
    assign ident_ch = is_alpha(i_byte) || is_digit(i_byte) || (i_byte == CH_UNDERSCORE);
    assign kw_hit   = r_kw && (r_run == PW'(KW_LEN));

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_origin = r_origin;
        n_run    = r_run;
        n_kw     = r_kw;
        va       = 1'b0;
        vb       = 1'b0;
        ta       = '0;
        tb       = '0;
        do_idle  = 1'b0;
        if (is_end) begin
            unique case (r_mode)
                M_STR: begin
                    va = 1'b1;
                    ta = mk(K_UNCLOSED, r_origin, r_run);
                end
                M_NUM: begin
                    va = 1'b1;
                    ta = mk(K_NUMBER, r_origin, r_run);
                end
                M_IDENT: begin
                    va = 1'b1;
                    ta = mk(kw_hit ? K_LOCAL : K_IDENT, r_origin, r_run);
                end
                default: ;
            endcase
            vb       = 1'b1;
            tb       = mk(K_END, r_pos, '0);
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_origin = '0;
            n_run    = '0;
            n_kw     = 1'b0;
        end else begin
            n_pos = sat_inc(r_pos);
            unique case (r_mode)
                M_NUM: begin
                    if (is_digit(i_byte)) begin
                        n_run = sat_inc(r_run);
                    end else begin
                        va      = 1'b1;
                        ta      = mk(K_NUMBER, r_origin, r_run);
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (ident_ch) begin
                        if (!((r_run < PW'(KW_LEN)) && (i_byte == kw_char(r_run[2:0])))) begin
                            n_kw = 1'b0;
                        end
                        n_run = sat_inc(r_run);
                    end else begin
                        va      = 1'b1;
                        ta      = mk(kw_hit ? K_LOCAL : K_IDENT, r_origin, r_run);
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        va     = 1'b1;
                        ta     = mk(K_STRING, r_origin, r_run);
                        n_mode = M_IDLE;
                    end else begin
                        n_run = sat_inc(r_run);
                    end
                end
                M_ERR: ;
                default: do_idle = 1'b1;
            endcase

            // Byte lexed from the idle state, possibly right after a flush
            if (do_idle) begin
                if (is_space(i_byte)) begin
                    // skipped
                end else if (i_byte == CH_ASSIGN) begin
                    vb = 1'b1;
                    tb = mk(K_ASSIGN, r_pos, PW'(1));
                end else if (i_byte == CH_COMMA) begin
                    vb = 1'b1;
                    tb = mk(K_COMMA, r_pos, PW'(1));
                end else if (i_byte == CH_LPAREN) begin
                    vb = 1'b1;
                    tb = mk(K_LPAREN, r_pos, PW'(1));
                end else if (i_byte == CH_RPAREN) begin
                    vb = 1'b1;
                    tb = mk(K_RPAREN, r_pos, PW'(1));
                end else if (is_digit(i_byte)) begin
                    n_mode   = M_NUM;
                    n_origin = r_pos;
                    n_run    = PW'(1);
                end else if (is_alpha(i_byte) || (i_byte == CH_UNDERSCORE)) begin
                    n_mode   = M_IDENT;
                    n_origin = r_pos;
                    n_run    = PW'(1);
                    n_kw     = (i_byte == kw_char(3'd0));
                end else if (i_byte == CH_QUOTE) begin
                    n_mode   = M_STR;
                    n_origin = sat_inc(r_pos);
                    n_run    = '0;
                end else begin
                    vb     = 1'b1;
                    tb     = mk(K_UNKNOWN, r_pos, PW'(1));
                    n_mode = M_ERR;
                end
            end
        end
    end

    // Compact the two candidate slots so the first result always sits in tok0
    always_comb begin
        if (va) begin
            o_pair.tok0 = ta;
            o_pair.tok1 = tb;
            o_pair.two  = vb;
        end else begin
            o_pair.tok0 = tb;
            o_pair.tok1 = '0;
            o_pair.two  = 1'b0;
        end
    end

    assign o_push = i_accept && (va || vb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_origin <= '0;
            r_run    <= '0;
            r_kw     <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_run    <= n_run;
            r_kw     <= n_kw;
        end
    end

endmodule

FILE: src/acl_tok_queue.sv
// acl_tok_queue: two-entry queue of result pairs; serialises each pair onto the output,
// one token per handshake. Depends on acl_pkg.
`timescale 1ns / 1ps

module acl_tok_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  acl_pkg::t_pair  i_pair,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output acl_pkg::t_token o_tok,
    output logic            o_last
);
    import acl_pkg::*;

    t_pair      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr, r_sub;
    logic [1:0] r_count, n_count;
    t_pair      head;
    logic       pop, take;

    assign head    = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_ready = (r_count != 2'd2);
    assign o_tok   = r_sub ? head.tok1 : head.tok0;
    assign o_last  = r_sub || !head.two;
    assign take    = o_valid && i_ready;
    assign pop     = take && o_last;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_sub    <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (take) begin
                r_sub <= 1'b1;
            end
        end
    end

endmodule

FILE: src/assignment_call_lexer_unit.sv
// assignment_call_lexer_unit: top level of the streaming lexer for assignment and call
// statements. Depends on acl_pkg, acl_lex_core and acl_tok_queue.
`timescale 1ns / 1ps

// Source bytes enter on the slave stream, one item per byte; tlast high (or a zero byte)
// ends the source, flushes any pending token and emits an end token, after which offsets
// restart at zero. Tokens leave on the master stream as kind, start offset and length,
// with tlast marking the final token caused by one input item. An item is lexed in the
// cycle it is accepted: the lexer state registers and one pass of byte classification
// produce its tokens, which go into a two-entry result queue. The slave side takes one
// byte every cycle while the queue has a free entry. An item that yields two tokens (a
// number or identifier ended by a punctuation or unknown byte, or an end of source after
// a pending token) needs two output handshakes, so the output stream sets the sustained
// rate at one token per cycle while m_axis_tready is high.
// Offsets and lengths saturate at 2^POSITION_BITS - 1 and at 65535 on the ports.
module assignment_call_lexer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Source bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_source
    // Tokens
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [acl_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
                                        // [3:0] token_kind, [19:4] token_start,
                                        // [35:20] token_length, [39:36] zero
    output logic        m_axis_tlast    // last_of_run
);
    import acl_pkg::*;

    logic   accept, push;
    t_pair  pair;
    t_token tok;

    assign accept = s_axis_tvalid && s_axis_tready;

    acl_lex_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_push   (push),
        .o_pair   (pair)
    );

    acl_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (tok),
        .o_last  (m_axis_tlast)
    );

    // Pack token fields, kind in the lowest bits
    assign m_axis_tdata = {4'b0, tok.length, tok.start, tok.kind};

endmodule
